/* sv/dqz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dqz_pkg;

  // register map (index = byte address / 4)
  localparam logic [2:0] REG_BIT_WIDTH        = 3'd0;
  localparam logic [2:0] REG_VALUES_PER_GROUP = 3'd1;
  localparam logic [2:0] REG_ROW_LENGTH       = 3'd2;
  localparam logic [2:0] REG_GROUP_WORDS      = 3'd3;
  localparam logic [2:0] REG_GROUPS_PER_ROW   = 3'd4;
  localparam logic [2:0] REG_USE_OFFSETS      = 3'd5;

  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [3:0]  RST_BIT_WIDTH        = 4'd4;
  localparam logic [14:0] RST_VALUES_PER_GROUP = 15'd128;
  localparam logic [14:0] RST_ROW_LENGTH       = 15'd4096;
  localparam logic [12:0] RST_GROUP_WORDS      = 13'd16;
  localparam logic [14:0] RST_GROUPS_PER_ROW   = 15'd32;

  localparam int unsigned MAX_ROW_LENGTH_DEF = 16384;
  localparam logic [12:0] GROUP_WORD_LIMIT   = 13'd4096;
  localparam logic [14:0] GROUP_COUNT_LIMIT  = 15'd16384;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

  typedef struct packed {
    logic [3:0]  bit_width;
    logic [14:0] values_per_group;
    logic [14:0] row_length;
    logic [12:0] group_words;
    logic [14:0] groups_per_row;
    logic        use_offsets;
  } cfg_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic [31:0] group_scale;
    logic [31:0] group_offset;
  } in_t;

  typedef struct packed {
    logic [31:0] weight_value;
    logic [13:0] column;
    logic        row_done;
    logic        last;
  } out_t;

  // one word's worth of work handed from front to back
  typedef struct packed {
    logic [38:0] bits;
    logic [5:0]  count;
    logic [29:0] col0;
    logic [31:0] scale;
    logic [31:0] offset;
  } job_t;

  function automatic logic [3:0] clamp_bits(input logic [3:0] bw);
    logic [3:0] r;
    if (bw == 4'd0) r = 4'd1;
    else if (bw > 4'd8) r = 4'd8;
    else r = bw;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/dqz_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface dqz_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/dqz_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module dqz_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dqz_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output dqz_pkg::cfg_t                    cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_width        <= dqz_pkg::RST_BIT_WIDTH;
      cfg.values_per_group <= dqz_pkg::RST_VALUES_PER_GROUP;
      cfg.row_length       <= dqz_pkg::RST_ROW_LENGTH;
      cfg.group_words      <= dqz_pkg::RST_GROUP_WORDS;
      cfg.groups_per_row   <= dqz_pkg::RST_GROUPS_PER_ROW;
      cfg.use_offsets      <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        dqz_pkg::REG_BIT_WIDTH:        cfg.bit_width        <= pwdata[3:0];
        dqz_pkg::REG_VALUES_PER_GROUP: cfg.values_per_group <= pwdata[14:0];
        dqz_pkg::REG_ROW_LENGTH:       cfg.row_length       <= pwdata[14:0];
        dqz_pkg::REG_GROUP_WORDS:      cfg.group_words      <= pwdata[12:0];
        dqz_pkg::REG_GROUPS_PER_ROW:   cfg.groups_per_row   <= pwdata[14:0];
        dqz_pkg::REG_USE_OFFSETS:      cfg.use_offsets      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dqz_pkg::REG_BIT_WIDTH:        prdata = {28'd0, cfg.bit_width};
      dqz_pkg::REG_VALUES_PER_GROUP: prdata = {17'd0, cfg.values_per_group};
      dqz_pkg::REG_ROW_LENGTH:       prdata = {17'd0, cfg.row_length};
      dqz_pkg::REG_GROUP_WORDS:      prdata = {19'd0, cfg.group_words};
      dqz_pkg::REG_GROUPS_PER_ROW:   prdata = {17'd0, cfg.groups_per_row};
      dqz_pkg::REG_USE_OFFSETS:      prdata = {31'd0, cfg.use_offsets};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/dqz_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module dqz_front (
  input  logic           clk,
  input  logic           rst,
  input  dqz_pkg::cfg_t  cfg,
  dqz_stream_if.sink     items,
  output logic           push,
  output dqz_pkg::job_t  job,
  input  logic           full
);

  localparam logic [11:0] RECIP3 = 12'd43;  // >>7
  localparam logic [11:0] RECIP5 = 12'd52;  // >>8
  localparam logic [11:0] RECIP6 = 12'd43;  // >>8
  localparam logic [11:0] RECIP7 = 12'd37;  // >>8

  logic        hold_valid;
  logic [31:0] hold_word;
  logic [31:0] hold_scale;
  logic [31:0] hold_offset;

  logic [7:0]  carry_bits;
  logic [2:0]  carry_count;
  logic [14:0] value_in_group;
  logic [11:0] word_in_group;
  logic [13:0] group_index;

  logic [3:0]  nbits;
  logic [12:0] wpg;
  logic [14:0] gpr;
  logic        stale;
  logic [2:0]  cc;
  logic [7:0]  cb;
  logic [38:0] buf_w;
  logic [5:0]  avail;
  logic [5:0]  fit;
  logic [14:0] room;
  logic [5:0]  k;
  logic [9:0]  used_w;
  logic [5:0]  used;
  logic [5:0]  rem;
  logic [14:0] vig_next;
  logic [12:0] wig_inc;
  logic        group_end;
  logic        keep;
  logic [38:0] rest;
  logic [7:0]  cmask;
  logic [14:0] gi_inc;
  logic        commit;

  // floor(a / b) for b in 1..8 and a in 32..39
  function automatic logic [5:0] fields_fit(input logic [5:0] a, input logic [3:0] b);
    logic [11:0] t;
    logic [5:0]  r;
    t = 12'd0;
    case (b)
      4'd1: r = a;
      4'd2: r = a >> 1;
      4'd3: begin t = 12'(a) * RECIP3; r = 6'(t >> 7); end
      4'd4: r = a >> 2;
      4'd5: begin t = 12'(a) * RECIP5; r = 6'(t >> 8); end
      4'd6: begin t = 12'(a) * RECIP6; r = 6'(t >> 8); end
      4'd7: begin t = 12'(a) * RECIP7; r = 6'(t >> 8); end
      default: r = a >> 3;
    endcase
    return r;
  endfunction

  assign items.ready = !hold_valid;

  always_comb begin
    nbits = dqz_pkg::clamp_bits(cfg.bit_width);
    if (cfg.group_words == 13'd0) wpg = 13'd1;
    else if (cfg.group_words > dqz_pkg::GROUP_WORD_LIMIT) wpg = dqz_pkg::GROUP_WORD_LIMIT;
    else wpg = cfg.group_words;
    if (cfg.groups_per_row == 15'd0) gpr = 15'd1;
    else if (cfg.groups_per_row > dqz_pkg::GROUP_COUNT_LIMIT) gpr = dqz_pkg::GROUP_COUNT_LIMIT;
    else gpr = cfg.groups_per_row;

    // carry left over from a wider bit width is thrown away
    stale = {1'b0, carry_count} >= nbits;
    cc    = stale ? 3'd0 : carry_count;
    cb    = stale ? 8'd0 : carry_bits;
    buf_w = (39'(hold_word) << cc) | 39'(cb);
    avail = 6'd32 + 6'(cc);
    fit   = fields_fit(avail, nbits);
    room  = (cfg.values_per_group > value_in_group) ?
            cfg.values_per_group - value_in_group : 15'd0;
    k     = (room < 15'(fit)) ? room[5:0] : fit;
    used_w = 10'(k) * 10'(nbits);
    used   = used_w[5:0];
    rem    = avail - used;

    vig_next  = value_in_group + 15'(k);
    wig_inc   = 13'(word_in_group) + 13'd1;
    group_end = wig_inc >= wpg;
    keep      = !group_end && (vig_next < cfg.values_per_group) && (rem < 6'd8);
    rest      = buf_w >> used;
    cmask     = 8'((9'd1 << rem[2:0]) - 9'd1);
    gi_inc    = 15'(group_index) + 15'd1;

    commit = hold_valid && ((k == 6'd0) || !full);
    push   = hold_valid && (k != 6'd0) && !full;

    job.bits   = buf_w;
    job.count  = k;
    job.col0   = 30'(group_index) * 30'(cfg.values_per_group) + 30'(value_in_group);
    job.scale  = hold_scale;
    job.offset = cfg.use_offsets ? hold_offset : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (items.valid && !hold_valid) begin
      hold_word   <= items.data.packed_word;
      hold_scale  <= items.data.group_scale;
      hold_offset <= items.data.group_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      carry_bits     <= 8'd0;
      carry_count    <= 3'd0;
      value_in_group <= 15'd0;
      word_in_group  <= 12'd0;
      group_index    <= 14'd0;
    end else begin
      if (items.valid && !hold_valid) begin
        hold_valid <= 1'b1;
      end else if (commit) begin
        hold_valid  <= 1'b0;
        carry_bits  <= keep ? (rest[7:0] & cmask) : 8'd0;
        carry_count <= keep ? rem[2:0] : 3'd0;
        if (group_end) begin
          word_in_group  <= 12'd0;
          value_in_group <= 15'd0;
          group_index    <= (gi_inc >= gpr) ? 14'd0 : gi_inc[13:0];
        end else begin
          word_in_group  <= wig_inc[11:0];
          value_in_group <= vig_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/dqz_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module dqz_queue #(
  parameter int unsigned DEPTH = dqz_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dqz_pkg::job_t  push_data,
  input  logic           pop,
  output dqz_pkg::job_t  head,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dqz_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= bump(wr_ptr);
      if (pop && !empty) rd_ptr <= bump(rd_ptr);
      if ((push && !full) && !(pop && !empty)) count <= count + CW'(1);
      else if (!(push && !full) && (pop && !empty)) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

/* sv/dqz_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module dqz_back #(
  parameter int unsigned MAX_ROW_LENGTH = dqz_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dqz_pkg::cfg_t  cfg,
  input  dqz_pkg::job_t  head,
  input  logic           empty,
  output logic           pop,
  dqz_stream_if.source   results
);

  localparam logic [14:0] ROW_CAP = 15'((MAX_ROW_LENGTH > 32767) ? 32767 : MAX_ROW_LENGTH);

  typedef struct packed {
    logic [13:0] column;
    logic        row_done;
    logic        last;
  } tag_t;

  function automatic logic [4:0] msb32(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [14:0] rowlen;
  logic [3:0]  nbits;
  logic        en;

  // working word
  logic        wvalid;
  logic [38:0] wbuf;
  logic [5:0]  wcnt;
  logic [29:0] wcol;
  logic [31:0] wscale;
  logic [31:0] woff;
  logic [29:0] span;
  logic [5:0]  e_cnt;
  logic        issue;

  // stage 1: integer x mantissa
  logic        v1;
  logic [31:0] m1;
  logic [7:0]  e1;
  logic        sg1, sp1;
  logic [31:0] spv1, off1;
  tag_t        tag1;
  // stage 2: normalize product
  logic        v2;
  logic [31:0] mn2;
  logic [8:0]  x2;
  logic        sg2, dir2;
  logic [31:0] dv2, off2;
  tag_t        tag2;
  // stage 3: rounded product
  logic        v3;
  logic [31:0] pr3, off3;
  tag_t        tag3;
  // stage 4: aligned operands
  logic        v4;
  logic [26:0] a4, b4;
  logic [7:0]  e4;
  logic        sg4, sub4, sp4;
  logic [31:0] spv4;
  tag_t        tag4;
  // stage 5: raw sum
  logic        v5;
  logic [27:0] s5;
  logic [7:0]  e5;
  logic        sg5, sub5, sp5;
  logic [31:0] spv5;
  tag_t        tag5;
  // stage 6: normalized sum
  logic        v6;
  logic [26:0] n6;
  logic [8:0]  e6;
  logic        sg6, z6, sp6;
  logic [31:0] spv6;
  tag_t        tag6;
  // stage 7: output register
  logic        v7;
  dqz_pkg::out_t o7;

  assign nbits  = dqz_pkg::clamp_bits(cfg.bit_width);
  assign rowlen = (cfg.row_length > ROW_CAP) ? ROW_CAP : cfg.row_length;
  assign en     = !v7 || results.ready;
  assign issue  = wvalid && en;
  assign pop    = !wvalid && !empty;

  assign results.valid = v7;
  assign results.data  = o7;

  // values past the row length form a suffix of the word; drop them up front
  always_comb begin
    span  = (30'(rowlen) > head.col0) ? 30'(rowlen) - head.col0 : 30'd0;
    e_cnt = (span < 30'(head.count)) ? span[5:0] : head.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
    end else if (pop) begin
      wvalid <= e_cnt != 6'd0;
    end else if (issue && wcnt == 6'd1) begin
      wvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      wbuf   <= head.bits;
      wcnt   <= e_cnt;
      wcol   <= head.col0;
      wscale <= head.scale;
      woff   <= head.offset;
    end else if (issue) begin
      wbuf <= wbuf >> nbits;
      wcnt <= wcnt - 6'd1;
      wcol <= wcol + 30'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= issue; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    logic [7:0]  q;
    logic [7:0]  se;
    logic [23:0] sm;
    q  = wbuf[7:0] & 8'((9'd1 << nbits) - 9'd1);
    se = wscale[30:23];
    sm = {se != 8'd0, wscale[22:0]};
    if (en) begin
      m1  <= 32'(q) * 32'(sm);
      e1  <= (se == 8'd0) ? 8'd1 : se;
      sg1 <= wscale[31];
      sp1 <= se == 8'hFF;
      if (wscale[22:0] != 23'd0) spv1 <= wscale | dqz_pkg::FP_QUIET_BIT;
      else if (q == 8'd0) spv1 <= dqz_pkg::FP_DEFAULT_NAN;
      else spv1 <= {wscale[31], 8'hFF, 23'd0};
      off1 <= woff;
      tag1.column   <= wcol[13:0];
      tag1.row_done <= (wcol + 30'd1) == 30'(rowlen);
      tag1.last     <= wcnt == 6'd1;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    logic [4:0] p;
    logic       exact;
    p     = msb32(m1);
    exact = (e1 == 8'd1) && (m1[31:24] == 8'd0);
    if (en) begin
      mn2  <= m1 << (5'd31 - p);
      x2   <= 9'(e1) + 9'(p) - 9'd23;
      sg2  <= sg1;
      dir2 <= sp1 || (m1 == 32'd0) || exact;
      if (sp1) dv2 <= spv1;
      else if (m1 == 32'd0) dv2 <= {sg1, 31'd0};
      else dv2 <= {sg1, m1[30:0]};
      off2 <= off1;
      tag2 <= tag1;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    logic inc;
    inc = mn2[7] && ((mn2[6:0] != 7'd0) || mn2[8]);
    if (en) begin
      if (dir2) pr3 <= dv2;
      else if (x2 >= 9'd255) pr3 <= {sg2, 8'hFF, 23'd0};
      else pr3 <= {sg2, 31'({x2[7:0], mn2[30:8]}) + 31'(inc)};
      off3 <= off2;
      tag3 <= tag2;
    end
  end

  // stage 4: specials, swap, align
  always_ff @(posedge clk) begin
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [26:0] ms, sh, lostm;
    a_nan = (pr3[30:23] == 8'hFF) && (pr3[22:0] != 23'd0);
    b_nan = (off3[30:23] == 8'hFF) && (off3[22:0] != 23'd0);
    a_inf = (pr3[30:23] == 8'hFF) && (pr3[22:0] == 23'd0);
    b_inf = (off3[30:23] == 8'hFF) && (off3[22:0] == 23'd0);
    swap  = off3[30:0] > pr3[30:0];
    big   = swap ? off3 : pr3;
    sml   = swap ? pr3 : off3;
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = eb - es;
    ms    = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    if (d >= 8'd27) begin
      sh    = 27'd0;
      lostm = ms;
    end else begin
      sh    = ms >> d;
      lostm = ms & ((27'd1 << d) - 27'd1);
    end
    if (en) begin
      a4   <= {big[30:23] != 8'd0, big[22:0], 3'd0};
      b4   <= sh | 27'(lostm != 27'd0);
      e4   <= eb;
      sg4  <= big[31];
      sub4 <= pr3[31] ^ off3[31];
      sp4  <= a_nan || b_nan || a_inf || b_inf;
      if (a_nan) spv4 <= pr3 | dqz_pkg::FP_QUIET_BIT;
      else if (b_nan) spv4 <= off3 | dqz_pkg::FP_QUIET_BIT;
      else if (a_inf && b_inf && (pr3[31] != off3[31])) spv4 <= dqz_pkg::FP_DEFAULT_NAN;
      else if (a_inf) spv4 <= pr3;
      else spv4 <= off3;
      tag4 <= tag3;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en) begin
      s5   <= sub4 ? 28'(a4) - 28'(b4) : 28'(a4) + 28'(b4);
      e5   <= e4;
      sg5  <= sg4;
      sub5 <= sub4;
      sp5  <= sp4;
      spv5 <= spv4;
      tag5 <= tag4;
    end
  end

  // stage 6: normalize, stopping at the subnormal boundary
  always_ff @(posedge clk) begin
    logic [4:0] p, s;
    logic [7:0] lim;
    p   = msb32(32'(s5[26:0]));
    s   = 5'd26 - p;
    lim = e5 - 8'd1;
    if (8'(s) > lim) s = lim[4:0];
    if (en) begin
      z6   <= s5 == 28'd0;
      sg6  <= (s5 == 28'd0) ? (sg5 && !sub5) : sg5;
      sp6  <= sp5;
      spv6 <= spv5;
      tag6 <= tag5;
      if (s5[27]) begin
        n6 <= {s5[27:2], s5[1] | s5[0]};
        e6 <= 9'(e5) + 9'd1;
      end else begin
        n6 <= s5[26:0] << s;
        e6 <= 9'(e5) - 9'(s);
      end
    end
  end

  // stage 7: round and pack
  always_ff @(posedge clk) begin
    logic       inc;
    logic [7:0] ef;
    inc = n6[2] && (n6[1] || n6[0] || n6[3]);
    ef  = n6[26] ? e6[7:0] : 8'd0;
    if (en) begin
      if (sp6) o7.weight_value <= spv6;
      else if (z6) o7.weight_value <= {sg6, 31'd0};
      else if (e6 >= 9'd255) o7.weight_value <= {sg6, 8'hFF, 23'd0};
      else o7.weight_value <= {sg6, 31'({ef, n6[25:3]}) + 31'(inc)};
      o7.column   <= tag6.column;
      o7.row_done <= tag6.row_done;
      o7.last     <= tag6.last;
    end
  end

endmodule
`default_nettype wire

/* sv/grouped_nbit_dequantizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | payload                                      | request
// items    | in  | packed_word, group_scale, group_offset       | one packed 32-bit word
// results  | out | weight_value, column, row_done, last         | one fp32 weight
// apb      | in  | bit_width .. use_offsets at 4*index          | register write / read
//
// The front registers a word and hands it to the queue once the queue is not full; it
// takes no new word before then. The back loads a word from the queue when it holds
// none and then emits one value per cycle while the result output is not stalled;
// each value passes through the float pipeline stages to a registered output. Reset
// is synchronous and needs no clearing pass. A stalled result output freezes the
// float pipeline; the queue lets the front keep taking words until it fills.
module grouped_nbit_dequantizer #(
  parameter int unsigned MAX_ROW_LENGTH = dqz_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dqz_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  dqz_stream_if.sink                     items,
  dqz_stream_if.source                   results
);

  dqz_pkg::cfg_t cfg;
  dqz_pkg::job_t push_job;
  dqz_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  dqz_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dqz_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .items (items),
    .push  (push),
    .job   (push_job),
    .full  (full)
  );

  dqz_queue #(.DEPTH(dqz_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .full      (full),
    .empty     (empty)
  );

  dqz_back #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head_job),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule
`default_nettype wire

/* sim/grouped_nbit_dequantizer_test.sv */
`timescale 1ns / 1ps
module grouped_nbit_dequantizer_test;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE = 20;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dqz_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dqz_stream_if #(.payload_t(dqz_pkg::in_t)) item_ch ();
  dqz_stream_if #(.payload_t(dqz_pkg::out_t)) weight_ch ();

  grouped_nbit_dequantizer i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .items(item_ch.sink),
    .results(weight_ch.source)
  );

  // shadow registers and unpacking state
  dqz_pkg::cfg_t shadow;
  logic [7:0] carry_bits;
  int unsigned carry_count;
  int unsigned value_in_group;
  int unsigned word_in_group;
  int unsigned group_index;

  dqz_pkg::in_t word_q[$];
  dqz_pkg::out_t weight_q[$];
  int send_idle;
  int recv_stall;
  int errors;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fp32 arithmetic, round to nearest even ----------------
  function automatic logic [31:0] fp_pack(input logic s, input logic [127:0] m, input int e);
    int p;
    int sh;
    int be;
    logic [127:0] mant;
    logic [127:0] rem;
    logic [127:0] half;
    if (m == 0) return {s, 31'b0};
    p = 127;
    while (!m[p]) p--;
    sh = p - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else if (sh >= 128) begin
      mant = '0;
    end else begin
      mant = m >> sh;
      rem = m & ((128'b1 << sh) - 1);
      half = 128'b1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      sh++;
    end
    if (mant[23]) begin
      be = e + sh + 150;
      if (be >= 255) return {s, 8'hFF, 23'b0};
      return {s, be[7:0], mant[22:0]};
    end
    return {s, 8'b0, mant[22:0]};
  endfunction

  function automatic void fp_split(input logic [31:0] x, output logic [127:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = {105'b0, x[22:0]};
      e = -149;
    end else begin
      m = {104'b0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  function automatic logic [31:0] fp_scale(input logic [7:0] q, input logic [31:0] x);
    logic [127:0] m;
    int e;
    if (is_nan(x)) return x | dqz_pkg::FP_QUIET_BIT;
    if (is_inf(x)) return (q == 0) ? dqz_pkg::FP_DEFAULT_NAN : x;
    fp_split(x, m, e);
    return fp_pack(x[31], m * q, e);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] big;
    logic [127:0] sml;
    logic [127:0] r;
    logic sbig;
    logic ssml;
    logic s;
    int ea;
    int eb;
    int ebig;
    int d;
    if (is_nan(a)) return a | dqz_pkg::FP_QUIET_BIT;
    if (is_nan(b)) return b | dqz_pkg::FP_QUIET_BIT;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return dqz_pkg::FP_DEFAULT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    if (ma == 0 && mb == 0) return {a[31] & b[31], 31'b0};
    if (ea >= eb) begin
      big = ma; sbig = a[31]; sml = mb; ssml = b[31]; ebig = ea; d = ea - eb;
    end else begin
      big = mb; sbig = b[31]; sml = ma; ssml = a[31]; ebig = eb; d = eb - ea;
    end
    // far smaller operand only matters as a sticky bit
    if (d > 40) begin
      sml = (sml != 0) ? 128'd1 : 128'd0;
      d = 40;
    end
    big = big << d;
    if (sbig == ssml) begin
      r = big + sml; s = sbig;
    end else if (big >= sml) begin
      r = big - sml; s = sbig;
    end else begin
      r = sml - big; s = ssml;
    end
    if (r == 0) return 32'h0;
    return fp_pack(s, r, ebig - d);
  endfunction

  // ---------------- unpacking predictor ----------------
  function automatic void dequantize_word(input dqz_pkg::in_t w);
    int unsigned bits;
    int unsigned wpg;
    int unsigned gpr;
    int unsigned rowlen;
    int unsigned avail;
    int unsigned col;
    int n;
    logic [63:0] buf_bits;
    logic [7:0] mask;
    logic [31:0] offset;
    dqz_pkg::out_t res[32];
    bits = (shadow.bit_width == 0) ? 1 : (shadow.bit_width > 8) ? 8 : shadow.bit_width;
    wpg = (shadow.group_words == 0) ? 1 :
          (shadow.group_words > dqz_pkg::GROUP_WORD_LIMIT) ? 4096 : shadow.group_words;
    gpr = (shadow.groups_per_row == 0) ? 1 :
          (shadow.groups_per_row > dqz_pkg::GROUP_COUNT_LIMIT) ? 16384 : shadow.groups_per_row;
    rowlen = (shadow.row_length > dqz_pkg::MAX_ROW_LENGTH_DEF) ?
             dqz_pkg::MAX_ROW_LENGTH_DEF : shadow.row_length;
    mask = 8'((9'd1 << bits) - 1);
    offset = shadow.use_offsets ? w.group_offset : 32'h0;
    n = 0;
    if (carry_count >= bits) begin
      carry_bits = '0;
      carry_count = 0;
    end
    buf_bits = {56'b0, carry_bits} | ({32'b0, w.packed_word} << carry_count);
    avail = carry_count + 32;
    while (avail >= bits && value_in_group < shadow.values_per_group && n < 32) begin
      col = group_index * shadow.values_per_group + value_in_group;
      res[n].weight_value = fp_add(fp_scale(buf_bits[7:0] & mask, w.group_scale), offset);
      buf_bits = buf_bits >> bits;
      avail -= bits;
      value_in_group++;
      if (col < rowlen) begin
        res[n].column = col[13:0];
        res[n].row_done = (col + 1 == rowlen);
        res[n].last = 1'b0;
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) weight_q.push_back(res[i]);
    word_in_group++;
    if (word_in_group < wpg && value_in_group < shadow.values_per_group && avail < 8) begin
      carry_bits = buf_bits[7:0] & 8'((9'd1 << avail) - 1);
      carry_count = avail;
    end else begin
      carry_bits = '0;
      carry_count = 0;
    end
    if (word_in_group >= wpg) begin
      word_in_group = 0;
      value_in_group = 0;
      group_index++;
      if (group_index >= gpr) group_index = 0;
    end
  endfunction

  // ---------------- request driver, receiver, checker ----------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        item_ch.valid <= 1'b1;
        item_ch.data <= word_q.pop_front();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    weight_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) dequantize_word(item_ch.data);
    if (!rst && weight_ch.valid && weight_ch.ready) begin
      if (weight_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %h column %0d row_done %b last %b",
                   weight_ch.data.weight_value, weight_ch.data.column,
                   weight_ch.data.row_done, weight_ch.data.last);
      end else begin
        if (weight_ch.data !== weight_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: value %h/%h column %0d/%0d row_done %b/%b last %b/%b (exp/got)",
                     weight_q[0].weight_value, weight_ch.data.weight_value,
                     weight_q[0].column, weight_ch.data.column,
                     weight_q[0].row_done, weight_ch.data.row_done,
                     weight_q[0].last, weight_ch.data.last);
        end
        void'(weight_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (item_ch.valid && item_ch.ready) || (weight_ch.valid && weight_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      dqz_pkg::REG_BIT_WIDTH:        shadow.bit_width = value[3:0];
      dqz_pkg::REG_VALUES_PER_GROUP: shadow.values_per_group = value[14:0];
      dqz_pkg::REG_ROW_LENGTH:       shadow.row_length = value[14:0];
      dqz_pkg::REG_GROUP_WORDS:      shadow.group_words = value[12:0];
      dqz_pkg::REG_GROUPS_PER_ROW:   shadow.groups_per_row = value[14:0];
      dqz_pkg::REG_USE_OFFSETS:      shadow.use_offsets = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] bw, input logic [31:0] vpg, input logic [31:0] rl,
                           input logic [31:0] wpg, input logic [31:0] gpr, input logic [31:0] off);
    reg_write(dqz_pkg::REG_BIT_WIDTH, bw);
    reg_write(dqz_pkg::REG_VALUES_PER_GROUP, vpg);
    reg_write(dqz_pkg::REG_ROW_LENGTH, rl);
    reg_write(dqz_pkg::REG_GROUP_WORDS, wpg);
    reg_write(dqz_pkg::REG_GROUPS_PER_ROW, gpr);
    reg_write(dqz_pkg::REG_USE_OFFSETS, off);
  endtask

  task automatic send(input logic [31:0] w, input logic [31:0] s, input logic [31:0] o);
    dqz_pkg::in_t it;
    it.packed_word = w;
    it.group_scale = s;
    it.group_offset = o;
    word_q.push_back(it);
  endtask

  // sample away from the rising edge so driver and checker updates have landed
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || item_ch.valid || weight_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle = 0; recv_stall = 0; end
      1: begin send_idle = 54; recv_stall = 0; end
      2: begin send_idle = 0; recv_stall = 54; end
      default: begin send_idle = 38; recv_stall = 38; end
    endcase
  endtask

  function automatic logic [31:0] rand_fp();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      0: r = r & 32'h8000_0000;
      1: r = {r[31], 8'hFF, 23'b0};
      2: r = {r[31], 8'hFF, r[22:0] | 23'h1};
      3: r = {r[31], 8'h00, r[22:0]};
      4: r = r;
      5: r = {r[31], 8'(r[30:23] % 8'd10 + 8'd240), r[22:0]};
      default: r = {r[31], 8'(r[30:23] % 8'd40 + 8'd107), r[22:0]};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick(input logic [31:0] top, input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return top;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    weight_ch.ready = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    shadow.bit_width = dqz_pkg::RST_BIT_WIDTH;
    shadow.values_per_group = dqz_pkg::RST_VALUES_PER_GROUP;
    shadow.row_length = dqz_pkg::RST_ROW_LENGTH;
    shadow.group_words = dqz_pkg::RST_GROUP_WORDS;
    shadow.groups_per_row = dqz_pkg::RST_GROUPS_PER_ROW;
    shadow.use_offsets = 1'b0;
    carry_bits = '0;
    carry_count = 0;
    value_in_group = 0;
    word_in_group = 0;
    group_index = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    for (int i = 0; i < 4; i++) send($urandom, rand_fp(), rand_fp());
    drain();

    // specials: overflow, NaN, inf, signed zero, subnormal, cancellation
    configure(4, 8, 20, 1, 3, 1);
    send(32'h0000_0000, 32'h3F80_0000, 32'h0000_0000);
    send(32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0000);
    send(32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
    send(32'h1234_5678, 32'h7F80_0001, 32'h0000_0000);
    send(32'hF0F0_F0F0, 32'h7F80_0000, 32'hFF80_0000);
    send(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    send(32'hA5A5_A5A5, 32'h0080_0000, 32'hFFC0_0001);
    send(32'h5A5A_5A5A, 32'hBF00_0000, 32'h3F00_0000);
    send(32'h8765_4321, 32'h4B00_0000, 32'hCB00_0000);
    drain();

    // width 0 reads as 1: 32 values per word
    configure(0, 32, 40, 1, 2, 0);
    send(32'hFFFF_FFFF, 32'h4000_0000, 32'h0);
    send(32'h5555_5555, 32'hC000_0000, 32'h0);
    drain();

    // width above 8, pad words, straddling fields with overflow
    configure(15, 5, 9, 2, 2, 1);
    send(32'hFFFF_FFFF, 32'h3F80_0000, 32'h4000_0000);
    send(32'h0102_0304, 32'h3F80_0000, 32'h4000_0000);
    drain();
    configure(3, 24, 32'h7FFF, 2, 0, 1);
    send(32'hDEAD_BEEF, 32'h3E80_0000, 32'hBF80_0000);
    send(32'hFFFF_FFFF, 32'h3E80_0000, 32'hBF80_0000);
    send(32'h1234_5678, 32'h3E80_0000, 32'hBF80_0000);
    drain();
    // carry across a width change: widen the width with a group still open
    configure(5, 0, 0, 32'h1FFF, 32'h7FFF, 0);
    send(32'h0, 32'h3F80_0000, 32'h0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      configure($urandom_range(0, 15), pick(32'h7FFF, 1, 40), pick(32'h7FFF, 1, 120),
                pick(32'h1FFF, 1, 5), pick(32'h7FFF, 1, 6), $urandom_range(0, 1));
      set_idling(ph);
      for (int i = 0; i < 28; i++) send($urandom, rand_fp(), rand_fp());
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* grouped_nbit_dequantizer.f */
sv/dqz_pkg.sv
sv/dqz_stream_if.sv
sv/dqz_cfg.sv
sv/dqz_front.sv
sv/dqz_queue.sv
sv/dqz_back.sv
sv/grouped_nbit_dequantizer.sv
sim/grouped_nbit_dequantizer_test.sv
